>>> rtl/dpst_pkg.sv
// ----------------------------------------------------------------------------
// dpst_pkg: shared types and constants for the packet descriptor store
// Table geometry, result status codes, entry layout and sequencer states.
// ----------------------------------------------------------------------------
package dpst_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int STATUS_W    = 3;

	localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SEND    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] seq;
		logic [7:0]  kind;
		logic [15:0] life;
		logic [31:0] stamp;
		logic [15:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DUP,
		S_INS_DONE,
		S_RD,
		S_ELAPSE,
		S_DECIDE,
		S_OUT
	} state_t;

endpackage

>>> rtl/dedup_packet_store_ttl_sweep_top.sv
// ----------------------------------------------------------------------------
// dedup_packet_store_ttl_sweep_top: packet descriptor store with TTL sweep
// Ordered descriptor table with duplicate filtering on insert and a sweep
// that re-sends live entries and removes expired ones with compaction.
// ----------------------------------------------------------------------------
// Usage
// Input channel (in_valid/in_ready) takes one item at a time: op 0 inserts a
// descriptor, op 1 sweeps the table with now_secs as the current time.
// Output channel (out_valid/out_ready) returns results; last marks the final
// result of an item. An insert gives one result, a sweep one per stored
// entry, or a single empty-sweep result when the table holds nothing.
// An insert reads every stored entry once through the table RAM's single
// read port before its result appears. A sweep handles each entry in turn
// through RAM read, elapsed-time subtract, compare and write-back and result
// hand-over; while a result waits to be taken, the sweep waits with it.
// in_ready is high only while the sequencer is idle, so items are handled
// one after another.
// Reset empties the table (fill count zero); the RAM contents are not
// cleared, and their values are never used before being written.
// When the receiver stalls, the result register holds and the sweep waits.
// ----------------------------------------------------------------------------
module dedup_packet_store_ttl_sweep_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [31:0]                   src_addr,
	input  logic [31:0]                   dst_addr,
	input  logic [31:0]                   seq_number,
	input  logic [7:0]                    pkt_kind,
	input  logic [15:0]                   life_secs,
	input  logic [15:0]                   pkt_handle,
	input  logic [31:0]                   now_secs,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dpst_pkg::STATUS_W-1:0] status,
	output logic [15:0]                   out_handle,
	output logic [31:0]                   out_src,
	output logic [31:0]                   out_dst,
	output logic [31:0]                   out_seq,
	output logic [7:0]                    out_kind,
	output logic [15:0]                   out_life,
	output logic                          last
);

	import dpst_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] keep_q;
	logic             dup_q;
	logic             cmp_vld_s1;
	logic             out_valid_q;

	logic        sweep_q;
	entry_t      in_q;
	logic [31:0] elapsed_q;

	logic [STATUS_W-1:0] status_q;
	entry_t              res_q;
	logic                last_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           rd;

	logic        in_acc;
	logic        out_acc;
	logic        match;
	logic        full;
	logic        send;
	logic [15:0] left;
	logic        is_last;

	dpst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	assign match   = (rd.src == in_q.src) && (rd.dst == in_q.dst) &&
	                 (rd.seq == in_q.seq) && (rd.kind == in_q.kind);
	assign full    = (fill_q == CNT_W'(TABLE_DEPTH));
	// A current time behind the stored stamp was already turned into zero elapsed time.
	assign send    = (elapsed_q < {16'd0, rd.life});
	assign left    = rd.life - elapsed_q[15:0];
	assign is_last = ((idx_q + CNT_W'(1)) == fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == S_IDLE);
		ram_we    = 1'b0;
		ram_waddr = fill_q[IDX_W-1:0];
		ram_wdata = in_q;
		ram_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!op) begin
						state_d = S_DUP;
					end else if (fill_q == '0) begin
						state_d = S_OUT;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_DUP: begin
				if ((idx_q == fill_q) && !cmp_vld_s1) begin
					state_d = S_INS_DONE;
				end
			end
			S_INS_DONE: begin
				state_d = S_OUT;
				ram_we  = !dup_q && !full;
			end
			S_RD: begin
				state_d = S_ELAPSE;
			end
			S_ELAPSE: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d         = S_OUT;
				ram_we          = send;
				ram_waddr       = keep_q[IDX_W-1:0];
				ram_wdata       = rd;
				ram_wdata.life  = left;
				ram_wdata.stamp = in_q.stamp;
			end
			S_OUT: begin
				if (out_acc) begin
					state_d = (sweep_q && !last_q) ? S_RD : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			keep_q      <= '0;
			dup_q       <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q      <= '0;
						keep_q     <= '0;
						dup_q      <= 1'b0;
						cmp_vld_s1 <= 1'b0;
						if (op && (fill_q == '0)) begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_DUP: begin
					cmp_vld_s1 <= (idx_q != fill_q);
					if (idx_q != fill_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (cmp_vld_s1 && match) begin
						dup_q <= 1'b1;
					end
				end
				S_INS_DONE: begin
					out_valid_q <= 1'b1;
					if (!dup_q && !full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				S_DECIDE: begin
					out_valid_q <= 1'b1;
					if (send) begin
						keep_q <= keep_q + CNT_W'(1);
					end
				end
				S_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (sweep_q) begin
							if (last_q) begin
								fill_q <= keep_q;
							end else begin
								idx_q <= idx_q + CNT_W'(1);
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					sweep_q      <= op;
					in_q.src     <= src_addr;
					in_q.dst     <= dst_addr;
					in_q.seq     <= seq_number;
					in_q.kind    <= pkt_kind;
					in_q.life    <= life_secs;
					in_q.stamp   <= now_secs;
					in_q.handle  <= pkt_handle;
					status_q     <= ST_EMPTY;
					res_q.src    <= '0;
					res_q.dst    <= '0;
					res_q.seq    <= '0;
					res_q.kind   <= '0;
					res_q.life   <= '0;
					res_q.stamp  <= '0;
					res_q.handle <= pkt_handle;
					last_q       <= 1'b1;
				end
			end
			S_INS_DONE: begin
				status_q <= dup_q ? ST_DUP : (full ? ST_FULL : ST_STORED);
				res_q    <= in_q;
				last_q   <= 1'b1;
			end
			S_ELAPSE: begin
				elapsed_q <= (in_q.stamp >= rd.stamp) ? (in_q.stamp - rd.stamp) : 32'd0;
			end
			S_DECIDE: begin
				status_q     <= send ? ST_SEND : ST_EXPIRED;
				res_q.src    <= rd.src;
				res_q.dst    <= rd.dst;
				res_q.seq    <= rd.seq;
				res_q.kind   <= rd.kind;
				res_q.life   <= send ? left : 16'd0;
				res_q.stamp  <= rd.stamp;
				res_q.handle <= rd.handle;
				last_q       <= is_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_handle = res_q.handle;
	assign out_src    = res_q.src;
	assign out_dst    = res_q.dst;
	assign out_seq    = res_q.seq;
	assign out_kind   = res_q.kind;
	assign out_life   = res_q.life;
	assign last       = last_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count exceeds table depth");

	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_OUT))
		else $error("result shown outside the output state");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (keep_q <= idx_q))
		else $error("compaction write overtakes the read position");

	a_sweep_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_q && sweep_q && (state_q == S_OUT)) |=>
		(fill_q == $past(keep_q)))
		else $error("sweep did not commit the surviving count");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_INS_DONE) && !dup_q && !full) |=>
		(fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("stored insert did not grow the table");
`endif

endmodule

>>> rtl/dpst_ram.sv
// ----------------------------------------------------------------------------
// dpst_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dpst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
